// File: hw/rtl/bid_pkg.sv
// Shared types and constants for the bit-image decoder.
package bid_pkg;

    localparam int IMAGE_WIDTH_DEF  = 240;
    localparam int IMAGE_HEIGHT_DEF = 240;

    localparam logic [7:0] CHR_ESC    = 8'h1B;
    localparam logic [7:0] CHR_IMAGE  = 8'h2A;
    localparam logic [7:0] CHR_SKIP_A = 8'h41;
    localparam logic [7:0] CHR_SKIP_K = 8'h6B;
    localparam logic [7:0] MASK_MSB   = 8'h80;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_STREAM = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_CMD,
        PH_MODE,
        PH_CNT_LO,
        PH_CNT_HI,
        PH_COLS,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic draw;
        logic rd;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic acc_start;
        logic acc_draw;
        logic acc_read;
        logic clr_last;
        logic draw_last;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/bid_if.sv
// Handshake channels for input and result words.
interface bid_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] read_row;
    logic [4:0] read_col;

    modport source (output valid, output opcode, output data_byte, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input opcode, input data_byte, input read_row,
                    input read_col, output ready);
endinterface

interface bid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

// File: hw/rtl/bid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bid_ctrl.sv
// Sequencer: clear sweep, column read-modify-write, store read and result load.
module bid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bid_pkg::t_status i_status,
    output bid_pkg::t_cmd    o_cmd
);
    import bid_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                n_cmd.clear = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cmd.in_ready = 1'b1;
                priority if (i_status.acc_start) begin
                    n_state = S_CLEAR;
                end else if (i_status.acc_draw) begin
                    n_state = S_DRAW;
                end else if (i_status.acc_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW: begin
                n_cmd.draw = 1'b1;
                if (i_status.draw_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_cmd.rd = 1'b1;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_cmd = n_cmd;
endmodule

// File: hw/rtl/bid_dp.sv
// Datapath: stream parser, frame store addressing and output word register.
module bid_dp #(
    parameter int IMAGE_WIDTH  = bid_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = bid_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bid_in_if.sink           i_in,
    bid_out_if.source        o_out,
    input  bid_pkg::t_cmd    i_cmd,
    output bid_pkg::t_status o_status
);
    import bid_pkg::*;

    localparam int ROW_BYTES = (IMAGE_WIDTH + 7) / 8;
    localparam int DEPTH     = ROW_BYTES * IMAGE_HEIGHT;
    localparam int AW        = $clog2(DEPTH);
    localparam int XW        = $clog2(DEPTH + 16 * ROW_BYTES);
    localparam int BW        = $clog2(IMAGE_HEIGHT + 16);

    localparam logic [XW-1:0] ROW_STEP    = XW'(ROW_BYTES);
    localparam logic [XW-1:0] BAND_STEP   = XW'(8 * ROW_BYTES);
    localparam logic [XW-1:0] BOTTOM_BASE = XW'(DEPTH);
    localparam logic [BW-1:0] HEIGHT_B    = BW'(IMAGE_HEIGHT);
    localparam logic [BW-1:0] BAND_ROWS   = BW'(8);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);

    t_phase        r_phase;
    t_phase        n_phase;
    logic [7:0]    r_cnt_lo;
    logic [7:0]    n_cnt_lo;
    logic [15:0]   r_col_total;
    logic [15:0]   n_col_total;
    logic [15:0]   r_col_idx;
    logic [15:0]   n_col_idx;
    logic [BW-1:0] r_band;
    logic [BW-1:0] n_band;
    logic [XW-1:0] r_row_base;
    logic [XW-1:0] n_row_base;

    logic [AW-1:0] r_clr_addr;
    logic [XW-1:0] r_addr;
    logic [XW-1:0] r_wr_addr;
    logic [BW-1:0] r_row;
    logic [7:0]    r_bits;
    logic [7:0]    r_mask;
    logic [3:0]    r_k;
    logic          r_wr_pend;
    logic          r_rd_ok;
    logic          r_out_valid;
    logic [7:0]    r_out_data;

    logic          acc;
    logic          acc_stream;
    logic          draw_col;
    logic          row_ok;
    logic          rd_ok;
    logic [XW-1:0] rd_addr;
    logic [BW-1:0] band_adv;
    logic [15:0]   idx_inc;
    logic [XW-1:0] adv_base;
    logic [BW-1:0] adv_band;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    assign acc        = i_in.valid && i_cmd.in_ready;
    assign acc_stream = acc && (t_opcode'(i_in.opcode) == OP_STREAM);
    assign draw_col   = (r_phase == PH_COLS) && (r_col_idx < 16'(IMAGE_WIDTH));
    assign row_ok     = r_row < HEIGHT_B;
    assign rd_ok      = (11'(i_in.read_row) < 11'(IMAGE_HEIGHT))
                     && (8'(i_in.read_col) < 8'(ROW_BYTES));
    assign rd_addr    = XW'(i_in.read_row) * ROW_STEP + XW'(i_in.read_col);
    assign band_adv   = r_band + BAND_ROWS;
    assign idx_inc    = r_col_idx + 16'd1;

    always_comb begin
        if (band_adv > HEIGHT_B) begin
            adv_band = HEIGHT_B;
            adv_base = BOTTOM_BASE;
        end else begin
            adv_band = band_adv;
            adv_base = r_row_base + BAND_STEP;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_cnt_lo    = r_cnt_lo;
        n_col_total = r_col_total;
        n_col_idx   = r_col_idx;
        n_band      = r_band;
        n_row_base  = r_row_base;
        unique case (r_phase)
            PH_TEXT: begin
                if (i_in.data_byte == CHR_ESC) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                priority if (i_in.data_byte == CHR_IMAGE) begin
                    n_phase = PH_MODE;
                end else if (i_in.data_byte == CHR_SKIP_A
                          || i_in.data_byte == CHR_SKIP_K) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_TEXT;
                end
            end
            PH_MODE: begin
                n_phase = PH_CNT_LO;
            end
            PH_CNT_LO: begin
                n_cnt_lo = i_in.data_byte;
                n_phase  = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                n_col_total = {i_in.data_byte, r_cnt_lo};
                n_col_idx   = 16'd0;
                if ({i_in.data_byte, r_cnt_lo} == 16'd0) begin
                    n_band     = adv_band;
                    n_row_base = adv_base;
                    n_phase    = PH_TEXT;
                end else begin
                    n_phase = PH_COLS;
                end
            end
            PH_COLS: begin
                n_col_idx = idx_inc;
                if (idx_inc == r_col_total) begin
                    n_band     = adv_band;
                    n_row_base = adv_base;
                    n_phase    = PH_TEXT;
                end
            end
            default: begin
                n_phase = PH_TEXT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TEXT;
            r_cnt_lo    <= '0;
            r_col_total <= '0;
            r_col_idx   <= '0;
            r_band      <= '0;
            r_row_base  <= '0;
        end else if (acc && t_opcode'(i_in.opcode) == OP_START) begin
            r_phase     <= PH_TEXT;
            r_cnt_lo    <= '0;
            r_col_total <= '0;
            r_col_idx   <= '0;
            r_band      <= '0;
            r_row_base  <= '0;
        end else if (acc_stream) begin
            r_phase     <= n_phase;
            r_cnt_lo    <= n_cnt_lo;
            r_col_total <= n_col_total;
            r_col_idx   <= n_col_idx;
            r_band      <= n_band;
            r_row_base  <= n_row_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (acc && t_opcode'(i_in.opcode) == OP_START) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= (r_clr_addr == LAST_ADDR) ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_wr_pend <= 1'b0;
        end else if (acc_stream && draw_col) begin
            r_k       <= '0;
            r_wr_pend <= 1'b0;
        end else if (i_cmd.draw && !r_k[3]) begin
            r_k       <= r_k + 4'd1;
            r_wr_pend <= r_bits[7] && row_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_stream && draw_col) begin
            r_addr <= r_row_base + XW'(r_col_idx[15:3]);
            r_row  <= r_band;
            r_bits <= i_in.data_byte;
            r_mask <= MASK_MSB >> r_col_idx[2:0];
        end else if (acc && t_opcode'(i_in.opcode) == OP_READ) begin
            r_addr  <= rd_addr;
            r_rd_ok <= rd_ok;
        end else if (i_cmd.draw && !r_k[3]) begin
            r_addr    <= r_addr + ROW_STEP;
            r_wr_addr <= r_addr;
            r_row     <= r_row + BW'(1);
            r_bits    <= {r_bits[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= r_rd_ok ? ram_rdata : 8'd0;
        end
    end

    assign ram_we    = i_cmd.clear || (i_cmd.draw && r_wr_pend);
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_wr_addr[AW-1:0];
    assign ram_wdata = i_cmd.clear ? 8'd0 : (ram_rdata | r_mask);
    assign ram_re    = (i_cmd.draw && !r_k[3] && row_ok) || (i_cmd.rd && r_rd_ok);

    bid_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready       = i_cmd.in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_byte = r_out_data;

    assign o_status.acc_start = acc && (t_opcode'(i_in.opcode) == OP_START);
    assign o_status.acc_draw  = acc_stream && draw_col;
    assign o_status.acc_read  = acc && (t_opcode'(i_in.opcode) == OP_READ);
    assign o_status.clr_last  = r_clr_addr == LAST_ADDR;
    assign o_status.draw_last = r_k[3];
    assign o_status.out_free  = !r_out_valid || o_out.ready;
endmodule

// File: hw/rtl/printer_bit_image_to_bitmap_top.sv
// Bit-image printer stream decoder top level.
// Stream words: a stream byte, or a column byte off the image, leaves the input ready for the
//   next word; a column byte on the image holds it for a read-modify-write of each band row,
//   one row read a cycle, last write after. Read word: address registered on acceptance, store
//   read in S_READ, result loaded in S_RESP once the output register is free; next word taken
//   after the load, later while a waiting result is stalled. Reset and the start opcode clear
//   all IMAGE_HEIGHT * ceil(IMAGE_WIDTH / 8) store bytes (7200 at 240 x 240) before new input.
module printer_bit_image_to_bitmap_top #(
    parameter int IMAGE_WIDTH  = bid_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = bid_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bid_in_if.sink    i_in,
    bid_out_if.source o_out
);
    import bid_pkg::*;

    t_cmd    cmd;
    t_status status;

    bid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bid_dp #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (cmd),
        .o_status (status)
    );
endmodule
